/* src/plist_pkg.sv */
// ----------------------------------------------------------------------------
// plist_pkg: shared types and constants for the positional list engine
// Item structs, command and status codes, and cell control for the cell row.
// ----------------------------------------------------------------------------
package plist_pkg;

  // List capacity, one cell per entry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_LIST      = 3'd6
  } plist_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BOUNDS = 2'd2,
    STAT_FULL   = 2'd3
  } plist_status_e;

  // Cell row operation, broadcast to every cell
  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_OPEN,
    EDIT_CLOSE,
    EDIT_ROTATE
  } plist_edit_e;

  typedef struct packed {
    plist_edit_e              edit;
    logic        [CNT_W-1:0]  idx;
    logic        [CNT_W-1:0]  occ;
    logic signed [VAL_W-1:0]  value;
  } plist_ctl_t;

  typedef struct packed {
    plist_cmd_e               command;
    logic signed [VAL_W-1:0]  value;
    logic        [POS_W-1:0]  position;
  } plist_in_t;

  typedef struct packed {
    plist_status_e            status;
    logic signed [VAL_W-1:0]  entry_value;
    logic                     last;
    logic        [COUNT_W-1:0] count;
  } plist_out_t;

  // Occupancy reported in the result, kept to its low bits
  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] occ);
    logic [CNT_W+COUNT_W-1:0] wide;
    wide = {{COUNT_W{1'b0}}, occ};
    return wide[COUNT_W-1:0];
  endfunction

endpackage

/* src/plist_cell.sv */
// ----------------------------------------------------------------------------
// plist_cell: one list entry
// Holds one value and reloads from its neighbors, the insert value or the
// front entry, according to the broadcast edit and its own place in the row.
// ----------------------------------------------------------------------------
module plist_cell (
  input  logic                              clk_i,
  input  logic [plist_pkg::IDX_W-1:0]       idx_i,
  input  plist_pkg::plist_ctl_t             ctl_i,
  input  logic signed [plist_pkg::VAL_W-1:0] left_i,
  input  logic signed [plist_pkg::VAL_W-1:0] right_i,
  input  logic signed [plist_pkg::VAL_W-1:0] wrap_i,
  output logic signed [plist_pkg::VAL_W-1:0] data_o
);
  import plist_pkg::*;

  logic        [CNT_W-1:0] my_idx;
  logic        [CNT_W-1:0] my_next;
  logic signed [VAL_W-1:0] data_d;
  logic signed [VAL_W-1:0] data_q;

  assign my_idx  = CNT_W'(idx_i);
  assign my_next = my_idx + CNT_W'(1);

  // Next value: shift up on open, shift down on close, ring on rotate
  always_comb begin
    data_d = data_q;
    unique case (ctl_i.edit)
      EDIT_OPEN: begin
        if (my_idx == ctl_i.idx) begin
          data_d = ctl_i.value;
        end else if (my_idx > ctl_i.idx) begin
          data_d = left_i;
        end
      end
      EDIT_CLOSE: begin
        if (my_idx >= ctl_i.idx) begin
          data_d = right_i;
        end
      end
      EDIT_ROTATE: begin
        // last occupied cell takes the front entry
        data_d = (my_next == ctl_i.occ) ? wrap_i : right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* src/positional_list_engine_top.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_top: bounded ordered list on a row of shift cells
// Edits shift the cells at and above the edit point by one place; list-all rotates the
// occupied cells past the front, one entry per cycle.
// ----------------------------------------------------------------------------
// The result is registered and appears in the cycle after accept; a list-all run first enters the list state.
// Edits and single-result commands: one command per cycle, busy stays low.
// List-all on n entries: busy through the run, n results, one per cycle.
// Results cannot be stalled; result_valid_o marks each for one cycle.
// Reset: occupancy clears to empty; cell contents are not cleared.
module positional_list_engine_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  plist_pkg::plist_in_t   in_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output plist_pkg::plist_out_t  result_o
);
  import plist_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        occ_q, occ_d;
  logic [IDX_W-1:0]        k_q, k_d;
  logic                    res_valid_q, res_valid_d;
  plist_out_t              res_q, res_d;
  plist_ctl_t              ctl;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic [POS_W-1:0]        idx8;
  logic [POS_W-1:0]        occ8;
  logic signed [VAL_W-1:0] cell_data [DEPTH];

  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (occ_q == CNT_W'(DEPTH));
  assign empty  = (occ_q == '0);
  assign occ8   = POS_W'(occ_q);
  // position zero acts as position one
  assign idx8   = (in_i.position == '0) ? '0 : in_i.position - POS_W'(1);

  // Command decode, cell control and result build
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    k_d         = k_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ctl.edit    = EDIT_NONE;
    ctl.idx     = '0;
    ctl.occ     = occ_q;
    ctl.value   = in_i.value;

    if (state_q == S_LIST) begin
      // emit front entry, rotate the occupied cells
      ctl.edit          = EDIT_ROTATE;
      res_valid_d       = 1'b1;
      res_d.status      = STAT_OK;
      res_d.entry_value = cell_data[0];
      res_d.last        = (CNT_W'(k_q) + CNT_W'(1) == occ_q);
      res_d.count       = to_count(occ_q);
      k_d               = k_q + IDX_W'(1);
      if (res_d.last) begin
        state_d = S_IDLE;
      end
    end else if (accept) begin
      res_valid_d       = 1'b1;
      res_d.status      = STAT_OK;
      res_d.entry_value = '0;
      res_d.last        = 1'b1;
      unique case (in_i.command)
        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
          if (full) begin
            res_d.status = STAT_FULL;
          end else begin
            ctl.edit = EDIT_OPEN;
            if (in_i.command == CMD_INS_FRONT) begin
              ctl.idx = '0;
            end else if (in_i.command == CMD_INS_BACK || idx8 > occ8) begin
              ctl.idx = occ_q;
            end else begin
              ctl.idx = idx8[CNT_W-1:0];
            end
            occ_d = occ_q + CNT_W'(1);
          end
        end
        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
          if (empty) begin
            res_d.status = STAT_EMPTY;
          end else if (in_i.command == CMD_DEL_POS && idx8 >= occ8) begin
            res_d.status = STAT_BOUNDS;
          end else begin
            ctl.edit = EDIT_CLOSE;
            if (in_i.command == CMD_DEL_FRONT) begin
              ctl.idx = '0;
            end else if (in_i.command == CMD_DEL_BACK) begin
              ctl.idx = occ_q - CNT_W'(1);
            end else begin
              ctl.idx = idx8[CNT_W-1:0];
            end
            occ_d = occ_q - CNT_W'(1);
          end
        end
        CMD_LIST: begin
          if (empty) begin
            res_d.status = STAT_EMPTY;
          end else begin
            res_valid_d = 1'b0;
            k_d         = '0;
            state_d     = S_LIST;
          end
        end
        default: res_d.status = STAT_OK;
      endcase
      res_d.count = to_count(occ_d);
    end
  end

  // State, occupancy and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  // Row of cells, each linked to its neighbors and the front cell
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_w;
    logic signed [VAL_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    plist_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .wrap_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  assign busy_o         = (state_q == S_LIST);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Checks
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.command != CMD_LIST) |=> (result_valid_o && result_o.last))
    else $error("single-result command did not produce a final result");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(DEPTH))
    else $error("occupancy above capacity");

  a_list_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |=> (result_valid_o && result_o.status == STAT_OK))
    else $error("list run cycle without a result");

  a_list_holds_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |=> (occ_q == $past(occ_q)))
    else $error("occupancy changed during list run");

  a_fail_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != STAT_OK) |-> (occ_q == $past(occ_q)))
    else $error("failed command changed occupancy");

endmodule
